### rtl/core/assert_macros.svh
// assertion macros shared by the beamformer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/core/tmlb_pkg.sv
// shared types and constants of the two-mic lms beamformer
`default_nettype none

package tmlb_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 32;
	localparam int LR_W       = 32;
	localparam int GAIN_W     = 4;
	localparam int THR_W      = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int FRAC_BITS = 28;
	localparam int E8_SHIFT  = 20;
	localparam int E_W       = 44;
	localparam int E8_W      = E_W - E8_SHIFT;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int KLO_W = 20;
	localparam int KHI_W = 34;
	localparam int LO_W  = 15;
	localparam int MAG_W = 50;

	localparam logic [KHI_W-1:0] KHI_CAP = 34'h2_0000_0000;

	localparam logic [LR_W-1:0]   LR_RST   = 32'd0;
	localparam logic [GAIN_W-1:0] GAIN_RST = 4'd1;
	localparam logic [THR_W-1:0]  THR_RST  = 15'd500;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
	localparam logic signed [COEF_W-1:0]   COEF_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [COEF_W-1:0]   COEF_MIN   = 32'sh8000_0000;
	localparam logic signed [E_W-1:0]      ERR_MAX    = 44'sh7FF_F000_0000;
	localparam logic signed [E_W-1:0]      ERR_MIN    = 44'sh800_0000_0000;

	localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_THRESHOLD = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAC,
		ST_CHECK,
		ST_RES,
		ST_KMUL,
		ST_KSPLIT,
		ST_UPD_LO,
		ST_UPD_HI,
		ST_UPD_SUM,
		ST_UPD_WR
	} tmlb_state_t;

	typedef struct packed {
		logic mul_en;
		logic acc_clr;
		logic acc_add;
	} tmlb_alu_ctl_t;

endpackage

`default_nettype wire

### rtl/core/tmlb_if.sv
// handshake interfaces for sample, result and configuration channels
`default_nettype none

interface tmlb_in_if;
	import tmlb_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	modport source(output valid, output left_sample, output right_sample, input ready);
	modport sink(input valid, input left_sample, input right_sample, output ready);
endinterface

interface tmlb_out_if;
	import tmlb_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] out_sample;
	logic                       canceller_cleared;
	modport source(output valid, output out_sample, output canceller_cleared, input ready);
	modport sink(input valid, input out_sample, input canceller_cleared, output ready);
endinterface

interface tmlb_cfg_if;
	import tmlb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/tmlb_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module tmlb_ram #(
	parameter  int WIDTH = 16,
	parameter  int DEPTH = 64,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/tmlb_alu.sv
// shared multiplier with product register and accumulator
`default_nettype none

module tmlb_alu #(
	parameter int ACC_W = 54
) (
	input  logic                                   clk,
	input  tmlb_pkg::tmlb_alu_ctl_t                ctl,
	input  logic signed [tmlb_pkg::MUL_A_W-1:0]    op_a,
	input  logic signed [tmlb_pkg::MUL_B_W-1:0]    op_b,
	output logic signed [tmlb_pkg::MUL_P_W-1:0]    prod,
	output logic signed [ACC_W-1:0]                acc
);
	import tmlb_pkg::*;

	logic signed [MUL_P_W-1:0] mul_full;
	logic signed [MUL_P_W-1:0] prod_q;
	logic signed [ACC_W-1:0]   acc_q;

	assign mul_full = op_a * op_b;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= mul_full;
		end
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (ctl.acc_add) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

	assign prod = prod_q;
	assign acc  = acc_q;

endmodule

`default_nettype wire

### rtl/core/two_mic_lms_beamformer.sv
// two-mic lms beamformer top level: sequencer, registers, memories and shared multiplier
//
//  channel   dir  payload                              transaction
//  samples   in   left_sample, right_sample            valid & ready
//  result    out  out_sample, canceller_cleared        valid & ready
//  cfg       in   index, data (write only)             valid & ready, always ready
//
// a new item is taken only after the previous one is through; the single shared multiplier sets
// this: one fir pass, then two products per tap, no update pass when the canceller trips
// after reset a clearing pass zeroes all three memories, no item is taken
// a trip is followed by a clearing pass that zeroes history and taps
// the result sits in an output register; the sequencer waits only if it is still full and not being taken
`default_nettype none
`include "assert_macros.svh"

module two_mic_lms_beamformer #(
	parameter int TAPS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	tmlb_in_if.sink    samples,
	tmlb_out_if.source result,
	tmlb_cfg_if.sink   cfg
);
	import tmlb_pkg::*;

	localparam int TW    = $clog2(TAPS);
	localparam int DLEN  = TAPS / 2;
	localparam int DW    = (DLEN > 1) ? $clog2(DLEN) : 1;
	localparam int ACC_W = 48 + TW;
	localparam int EW2   = ACC_W + 1;
	localparam int GP_W  = SAMPLE_W + 1 + GAIN_W + 1;
	localparam int NW_W  = MAG_W + 2;

	tmlb_state_t state_q, state_d;

	// configuration registers
	logic [LR_W-1:0]   lr_q;
	logic [GAIN_W-1:0] gain_q;
	logic [THR_W-1:0]  thr_q;

	// sequencer control
	logic [TW-1:0] tap_q, hidx_q, hp_q, hp_next, hidx_next, tap_next;
	logic [DW-1:0] dp_q, dp_next;
	logic          tap_last, issue_done_q, clr_all_q;
	logic          v_s1, v_s2;
	logic          res_load, can_load;

	// memory ports
	logic                       hist_we, hist_re, coef_we, coef_re, dly_we, dly_re;
	logic [TW-1:0]              hist_waddr, hist_raddr, coef_waddr, coef_raddr;
	logic [DW-1:0]              dly_waddr;
	logic signed [SAMPLE_W-1:0] hist_wdata, hist_rd, dly_wdata, dly_rd;
	logic signed [COEF_W-1:0]   coef_wdata, coef_rd;

	// shared unit
	tmlb_alu_ctl_t              alu_ctl;
	logic signed [MUL_A_W-1:0]  op_a;
	logic signed [MUL_B_W-1:0]  op_b;
	logic signed [MUL_P_W-1:0]  prod;
	logic signed [ACC_W-1:0]    acc;

	// datapath
	logic signed [SAMPLE_W:0]   sum17, diff17;
	logic signed [SAMPLE_W-1:0] s_val, d_val, s_q;
	logic signed [EW2-1:0]      dly_e, acc_e, lim_e, e_full;
	logic                       over;
	logic signed [E_W-1:0]      e_clamped, e_q;
	logic                       over_q;
	logic [E_W-1:0]             e_abs;
	logic [SAMPLE_W:0]          o_mag17;
	logic signed [SAMPLE_W:0]   o16, sel17;
	logic signed [GP_W-1:0]     gprod;
	logic signed [SAMPLE_W-1:0] res_val;
	logic [E8_W-1:0]            e8mag_q;
	logic                       e_neg_q;
	logic [MUL_A_W-1:0]         khi_raw;
	logic [KLO_W-1:0]           klo_q;
	logic [KHI_W-1:0]           khi_q;
	logic [SAMPLE_W-1:0]        ax, ax_q;
	logic                       neg_q;
	logic signed [COEF_W-1:0]   w_q;
	logic [LO_W-1:0]            lo_q;
	logic [MAG_W-1:0]           mag_q;
	logic signed [NW_W-1:0]     w_ext, m_ext, nw;
	logic signed [COEF_W-1:0]   nw_sat;

	// result register
	logic                       res_valid_q, res_cleared_q;
	logic signed [SAMPLE_W-1:0] res_sample_q;

	tmlb_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (hist_re),
		.raddr (hist_raddr),
		.rdata (hist_rd)
	);

	tmlb_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.re    (coef_re),
		.raddr (coef_raddr),
		.rdata (coef_rd)
	);

	tmlb_ram #(.WIDTH(SAMPLE_W), .DEPTH(DLEN)) u_dly_ram (
		.clk   (clk),
		.we    (dly_we),
		.waddr (dly_waddr),
		.wdata (dly_wdata),
		.re    (dly_re),
		.raddr (dp_q),
		.rdata (dly_rd)
	);

	tmlb_alu #(.ACC_W(ACC_W)) u_alu (
		.clk  (clk),
		.ctl  (alu_ctl),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod),
		.acc  (acc)
	);

	// index arithmetic
	assign tap_last  = (tap_q == TW'(TAPS - 1));
	assign tap_next  = tap_q + 1'b1;
	assign hidx_next = (hidx_q == TW'(TAPS - 1)) ? '0 : hidx_q + 1'b1;
	assign hp_next   = (hp_q == '0) ? TW'(TAPS - 1) : hp_q - 1'b1;
	assign dp_next   = (dp_q == DW'(DLEN - 1)) ? '0 : dp_q + 1'b1;

	// half-sum and half-difference, floor by arithmetic shift
	assign sum17  = {samples.left_sample[SAMPLE_W-1], samples.left_sample}
		+ {samples.right_sample[SAMPLE_W-1], samples.right_sample};
	assign diff17 = {samples.right_sample[SAMPLE_W-1], samples.right_sample}
		- {samples.left_sample[SAMPLE_W-1], samples.left_sample};
	assign s_val  = sum17[SAMPLE_W:1];
	assign d_val  = diff17[SAMPLE_W:1];

	// threshold test and error, all in q28
	assign acc_e  = EW2'(acc);
	assign dly_e  = EW2'(dly_rd) <<< FRAC_BITS;
	assign lim_e  = $signed(EW2'(thr_q) << FRAC_BITS);
	assign over   = (acc_e > lim_e) || (acc_e < -lim_e);
	assign e_full = dly_e - acc_e;

	always_comb begin
		if (e_full > EW2'(ERR_MAX)) begin
			e_clamped = ERR_MAX;
		end else if (e_full < EW2'(ERR_MIN)) begin
			e_clamped = ERR_MIN;
		end else begin
			e_clamped = e_full[E_W-1:0];
		end
	end

	// output sample: truncate the error toward zero (or take the half-sum on a trip), apply gain, saturate
	assign e_abs   = e_q[E_W-1] ? E_W'(-e_q) : E_W'(e_q);
	assign o_mag17 = {1'b0, e_abs[E_W-1:FRAC_BITS]};
	assign o16     = e_q[E_W-1] ? -$signed(o_mag17) : $signed(o_mag17);
	assign sel17   = over_q ? {s_q[SAMPLE_W-1], s_q} : o16;
	assign gprod   = sel17 * $signed({1'b0, gain_q});

	always_comb begin
		if (gprod > GP_W'(SAMPLE_MAX)) begin
			res_val = SAMPLE_MAX;
		end else if (gprod < GP_W'(SAMPLE_MIN)) begin
			res_val = SAMPLE_MIN;
		end else begin
			res_val = gprod[SAMPLE_W-1:0];
		end
	end

	// tap update pieces
	assign khi_raw = prod[MUL_A_W+E8_SHIFT-1:E8_SHIFT];
	assign ax      = hist_rd[SAMPLE_W-1] ? SAMPLE_W'(-hist_rd) : SAMPLE_W'(hist_rd);
	assign w_ext   = NW_W'(w_q);
	assign m_ext   = $signed({2'b00, mag_q});
	assign nw      = neg_q ? w_ext - m_ext : w_ext + m_ext;

	always_comb begin
		if (nw > NW_W'(COEF_MAX)) begin
			nw_sat = COEF_MAX;
		end else if (nw < NW_W'(COEF_MIN)) begin
			nw_sat = COEF_MIN;
		end else begin
			nw_sat = nw[COEF_W-1:0];
		end
	end

	assign can_load = !res_valid_q || result.ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d       = state_q;
		samples.ready = 1'b0;
		hist_we       = 1'b0;
		hist_waddr    = tap_q;
		hist_wdata    = '0;
		hist_re       = 1'b0;
		hist_raddr    = hidx_q;
		coef_we       = 1'b0;
		coef_waddr    = tap_q;
		coef_wdata    = '0;
		coef_re       = 1'b0;
		coef_raddr    = tap_q;
		dly_we        = 1'b0;
		dly_waddr     = dp_q;
		dly_wdata     = '0;
		dly_re        = 1'b0;
		alu_ctl       = '0;
		op_a          = '0;
		op_b          = '0;
		res_load      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				hist_we   = 1'b1;
				coef_we   = 1'b1;
				dly_we    = clr_all_q && (tap_q < TW'(DLEN));
				dly_waddr = tap_q[DW-1:0];
				if (tap_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					hist_we         = 1'b1;
					hist_waddr      = hp_next;
					hist_wdata      = d_val;
					dly_we          = 1'b1;
					dly_wdata       = s_val;
					dly_re          = 1'b1;
					alu_ctl.acc_clr = 1'b1;
					state_d         = ST_MAC;
				end
			end
			ST_MAC: begin
				hist_re         = !issue_done_q;
				coef_re         = !issue_done_q;
				alu_ctl.mul_en  = v_s1;
				alu_ctl.acc_add = v_s2;
				op_a            = MUL_A_W'(coef_rd);
				op_b            = MUL_B_W'(hist_rd);
				if (issue_done_q && !v_s1 && !v_s2) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = ST_RES;
			end
			ST_RES: begin
				if (can_load) begin
					res_load = 1'b1;
					state_d  = over_q ? ST_CLEAR : ST_KMUL;
				end
			end
			ST_KMUL: begin
				alu_ctl.mul_en = 1'b1;
				op_a           = $signed(MUL_A_W'(lr_q));
				op_b           = $signed(MUL_B_W'(e8mag_q));
				hist_re        = 1'b1;
				coef_re        = 1'b1;
				state_d        = ST_KSPLIT;
			end
			ST_KSPLIT: begin
				state_d = ST_UPD_LO;
			end
			ST_UPD_LO: begin
				alu_ctl.mul_en = 1'b1;
				op_a           = $signed(MUL_A_W'(klo_q));
				op_b           = $signed(MUL_B_W'(ax));
				state_d        = ST_UPD_HI;
			end
			ST_UPD_HI: begin
				alu_ctl.mul_en = 1'b1;
				op_a           = $signed(MUL_A_W'(khi_q));
				op_b           = $signed(MUL_B_W'(ax_q));
				state_d        = ST_UPD_SUM;
			end
			ST_UPD_SUM: begin
				state_d = ST_UPD_WR;
			end
			ST_UPD_WR: begin
				coef_we    = 1'b1;
				coef_wdata = nw_sat;
				if (tap_last) begin
					state_d = ST_IDLE;
				end else begin
					hist_re    = 1'b1;
					coef_re    = 1'b1;
					hist_raddr = hidx_next;
					coef_raddr = tap_next;
					state_d    = ST_UPD_LO;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer counters and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q        <= '0;
			hidx_q       <= '0;
			hp_q         <= '0;
			dp_q         <= '0;
			issue_done_q <= 1'b0;
			clr_all_q    <= 1'b1;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_MAC) && !issue_done_q;
			v_s2 <= v_s1;
			unique case (state_q)
				ST_CLEAR: begin
					tap_q <= tap_last ? '0 : tap_next;
					if (tap_last) begin
						clr_all_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (samples.valid) begin
						tap_q        <= '0;
						hidx_q       <= hp_next;
						hp_q         <= hp_next;
						dp_q         <= dp_next;
						issue_done_q <= 1'b0;
					end
				end
				ST_MAC: begin
					if (!issue_done_q) begin
						if (tap_last) begin
							issue_done_q <= 1'b1;
						end else begin
							tap_q  <= tap_next;
							hidx_q <= hidx_next;
						end
					end
				end
				ST_CHECK: begin
					tap_q  <= '0;
					hidx_q <= hp_q;
				end
				ST_UPD_WR: begin
					if (!tap_last) begin
						tap_q  <= tap_next;
						hidx_q <= hidx_next;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && samples.valid) begin
			s_q <= s_val;
		end
		if (state_q == ST_CHECK) begin
			e_q    <= e_clamped;
			over_q <= over;
		end
		if (state_q == ST_RES) begin
			e8mag_q <= e_abs[E_W-1:E8_SHIFT];
			e_neg_q <= e_q[E_W-1];
		end
		if (state_q == ST_KSPLIT) begin
			klo_q <= prod[KLO_W-1:0];
			// past the cap the tap saturates anyway for any nonzero history
			khi_q <= (khi_raw > MUL_A_W'(KHI_CAP)) ? KHI_CAP : khi_raw[KHI_W-1:0];
		end
		if (state_q == ST_UPD_LO) begin
			w_q   <= coef_rd;
			ax_q  <= ax;
			neg_q <= e_neg_q ^ hist_rd[SAMPLE_W-1];
		end
		if (state_q == ST_UPD_HI) begin
			lo_q <= prod[E8_SHIFT+LO_W-1:E8_SHIFT];
		end
		if (state_q == ST_UPD_SUM) begin
			mag_q <= MAG_W'(prod[MAG_W-2:0]) + MAG_W'(lo_q);
		end
	end

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= LR_RST;
			gain_q <= GAIN_RST;
			thr_q  <= THR_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_LEARNING_RATE:   lr_q   <= cfg.data[LR_W-1:0];
				CFG_OUTPUT_GAIN:     gain_q <= cfg.data[GAIN_W-1:0];
				CFG_RESET_THRESHOLD: thr_q  <= cfg.data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_sample_q  <= res_val;
			res_cleared_q <= over_q;
		end
	end

	assign result.valid             = res_valid_q;
	assign result.out_sample        = res_sample_q;
	assign result.canceller_cleared = res_cleared_q;

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, samples.valid && samples.ready, !samples.ready)
	`ASSERT_NEXT(a_clear_follows_trip, clk, arst_n, res_load && over_q, state_q == ST_CLEAR && tap_q == '0)
	`ASSERT_IMPLIES(a_mac_pipe_contained, clk, arst_n, v_s1 || v_s2, state_q == ST_MAC)

endmodule

`default_nettype wire
